/* rtl/core/hmc_pkg.sv */
// ============================================================================
// hmc_pkg: shared constants for the humidity mode controller
// Field widths, register indexes, reset values and controller mode codes.
// ============================================================================
package hmc_pkg;

    // Default structural parameters
    localparam int WINDOW_DEF    = 10;
    localparam int DUTY_BITS_DEF = 10;

    // Field widths
    localparam int HUM_W     = 10;
    localparam int TEMP_W    = 12;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 3;
    localparam int BAND_W    = 8;
    localparam int COOL_W    = 20;
    localparam int DRY_W     = 10;
    localparam int STEP_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AFTERCOOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUXCOOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRYDUTY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RAMPSTEP  = 3'd7;

    // Register reset values
    localparam logic [HUM_W-1:0]         TARGET_RST    = 10'd750;
    localparam logic [BAND_W-1:0]        BAND_RST      = 8'd30;
    localparam logic [COOL_W-1:0]        AFTERCOOL_RST = 20'd45000;
    localparam logic signed [TEMP_W-1:0] WARMUP_RST    = 12'sd640;
    localparam logic signed [TEMP_W-1:0] AUXCOOL_RST   = 12'sd960;
    localparam logic signed [TEMP_W-1:0] CRITICAL_RST  = 12'sd1120;
    localparam logic [DRY_W-1:0]         DRYDUTY_RST   = 10'd800;
    localparam logic [STEP_W-1:0]        RAMPSTEP_RST  = 8'd10;

    // Controller mode codes
    localparam logic [MODE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] ST_HUM  = 3'd1;
    localparam logic [MODE_W-1:0] ST_DEH  = 3'd2;
    localparam logic [MODE_W-1:0] ST_AFT  = 3'd3;
    localparam logic [MODE_W-1:0] ST_PROT = 3'd4;

    // Input beat kinds
    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_RAMP    = 1'b1;

endpackage

/* rtl/core/hmc_intf.sv */
// ============================================================================
// hmc_intf: valid/ready channels of the humidity mode controller
// Sample channel (control sample or ramp tick) and report channel.
// ============================================================================
interface hmc_sample_if;
    import hmc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [HUM_W-1:0]         humidity;
    logic                     humidity_ok;
    logic signed [TEMP_W-1:0] water_temp;
    logic                     water_ok;
    logic [TIME_W-1:0]        now_ms;

    modport source (output valid, mode, humidity, humidity_ok, water_temp, water_ok,
                    now_ms, input ready);
    modport sink   (input valid, mode, humidity, humidity_ok, water_temp, water_ok,
                    now_ms, output ready);
endinterface

interface hmc_report_if #(
    parameter int DUTY_BITS = hmc_pkg::DUTY_BITS_DEF
);
    import hmc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode_state;
    logic                 heater_on;
    logic                 pump_on;
    logic [DUTY_BITS-1:0] blower_duty;
    logic [DUTY_BITS-1:0] case_duty;
    logic [HUM_W-1:0]     humidity_avg;

    modport source (output valid, mode_state, heater_on, pump_on, blower_duty, case_duty,
                    humidity_avg, input ready);
    modport sink   (input valid, mode_state, heater_on, pump_on, blower_duty, case_duty,
                    humidity_avg, output ready);
endinterface

/* rtl/core/humidity_mode_controller_top.sv */
// ============================================================================
// humidity_mode_controller_top: humidity mode controller
// Moving-average humidity filter, five-mode climate state machine and
// soft-start duty ramp for blower and case fan, run by a small sequencer.
// ============================================================================
//
//  channel  | dir | handshake    | beat
//  ---------+-----+--------------+-------------------------------------------
//  sample   | in  | valid/ready  | control sample or ramp tick
//  report   | out | valid/ready  | mode, heater, pump, duties, avg humidity
//  cfg      | in  | cfg_we       | register index + write data, no read-back
//
//  Ramp tick: the duties step toward their goals, then the report is loaded. Control
//  sample: ring read and push when the humidity is valid, the threshold compares,
//  the mode update and, with a valid humidity, the bit-serial average divide.
//  One beat is in work at a time; sample.ready is high only while idle.
//  A finished result waits in the report register while the next beat is taken.
//  Reset gives the register defaults, idle mode and an empty filter.
//
module humidity_mode_controller_top #(
    parameter int WINDOW    = hmc_pkg::WINDOW_DEF,
    parameter int DUTY_BITS = hmc_pkg::DUTY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hmc_sample_if.sink                        sample,
    hmc_report_if.source                      report,
    input  logic                              cfg_we,
    input  logic [hmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmc_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import hmc_pkg::*;

    localparam int TW   = HUM_W + $clog2(WINDOW);   // ring total
    localparam int CW   = $clog2(WINDOW + 1);       // sample count
    localparam int PW   = $clog2(WINDOW);           // ring pointer
    localparam int PRW  = CW + 1 + TEMP_W;          // threshold product
    localparam int DCW  = $clog2(TW);               // divider step counter
    localparam int RW   = DUTY_BITS + 1;            // ramp sum
    localparam int XW   = (DUTY_BITS > DRY_W) ? DUTY_BITS : DRY_W;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    localparam logic [1:0] MUL_LO  = 2'd0;
    localparam logic [1:0] MUL_HI  = 2'd1;
    localparam logic [1:0] MUL_TGT = 2'd2;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_RAMP,
        SQ_RD,
        SQ_PUSH,
        SQ_MUL,
        SQ_FSM,
        SQ_DIV,
        SQ_DONE
    } seq_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [HUM_W-1:0]         target_reg;
    logic [BAND_W-1:0]        band_reg;
    logic [COOL_W-1:0]        after_cool_reg;
    logic signed [TEMP_W-1:0] warmup_reg;
    logic signed [TEMP_W-1:0] aux_level_reg;
    logic signed [TEMP_W-1:0] crit_reg;
    logic [DRY_W-1:0]         dry_reg;
    logic [STEP_W-1:0]        step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RST;
            band_reg       <= BAND_RST;
            after_cool_reg <= AFTERCOOL_RST;
            warmup_reg     <= WARMUP_RST;
            aux_level_reg  <= AUXCOOL_RST;
            crit_reg       <= CRITICAL_RST;
            dry_reg        <= DRYDUTY_RST;
            step_reg       <= RAMPSTEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:    target_reg     <= cfg_data[HUM_W-1:0];
                REG_BAND:      band_reg       <= cfg_data[BAND_W-1:0];
                REG_AFTERCOOL: after_cool_reg <= cfg_data[COOL_W-1:0];
                REG_WARMUP:    warmup_reg     <= $signed(cfg_data[TEMP_W-1:0]);
                REG_AUXCOOL:   aux_level_reg  <= $signed(cfg_data[TEMP_W-1:0]);
                REG_CRITICAL:  crit_reg       <= $signed(cfg_data[TEMP_W-1:0]);
                REG_DRYDUTY:   dry_reg        <= cfg_data[DRY_W-1:0];
                REG_RAMPSTEP:  step_reg       <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    seq_t                     seq_reg;
    logic [1:0]               mul_idx_reg;
    logic [DCW-1:0]           div_cnt_reg;

    logic [HUM_W-1:0]         hum_reg;
    logic                     hum_ok_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     temp_ok_reg;
    logic [TIME_W-1:0]        now_reg;

    logic [MODE_W-1:0]        mode_reg;
    logic [TIME_W-1:0]        cool_start_reg;
    logic [PW-1:0]            ptr_reg;
    logic [TW-1:0]            total_reg;
    logic                     filled_reg;
    logic                     pump_reg;
    logic [DUTY_BITS-1:0]     blower_goal_reg;
    logic [DUTY_BITS-1:0]     blower_now_reg;
    logic [DUTY_BITS-1:0]     case_goal_reg;
    logic [DUTY_BITS-1:0]     case_now_reg;
    logic [HUM_W-1:0]         avg_reg;

    logic                     lt_lo_reg;
    logic                     gt_hi_reg;
    logic                     ge_t_reg;
    logic                     le_t_reg;

    logic [TW-1:0]            div_reg;
    logic [CW-1:0]            rem_reg;

    logic [HUM_W-1:0]         ring_rd_reg;
    logic [HUM_W-1:0]         ring_mem [WINDOW];

    logic                     out_valid_reg;
    logic [MODE_W-1:0]        out_mode_reg;
    logic                     out_heater_reg;
    logic                     out_pump_reg;
    logic [DUTY_BITS-1:0]     out_blower_reg;
    logic [DUTY_BITS-1:0]     out_case_reg;
    logic [HUM_W-1:0]         out_avg_reg;

    // ------------------------------------------------------------------
    // Filter count and shared threshold multiplier
    // ------------------------------------------------------------------
    logic [CW-1:0]            count;
    logic [CW-1:0]            cnt_eff;
    logic [TW-1:0]            sum_eff;
    logic signed [TEMP_W-1:0] tgt_s;
    logic signed [TEMP_W-1:0] hys_s;
    logic signed [TEMP_W-1:0] mul_opnd;
    logic signed [PRW-1:0]    prod;
    logic signed [PRW-1:0]    sum_s;

    assign count   = filled_reg ? CW'(WINDOW) : CW'(ptr_reg);
    assign cnt_eff = (count == '0) ? CW'(1) : count;
    assign sum_eff = (count == '0) ? '0 : total_reg;
    assign tgt_s   = $signed({2'b00, target_reg});
    assign hys_s   = $signed({4'b0000, band_reg});

    always_comb
    begin
        case (mul_idx_reg)
            MUL_LO:  mul_opnd = tgt_s - hys_s;
            MUL_HI:  mul_opnd = tgt_s + hys_s;
            default: mul_opnd = tgt_s;
        endcase
    end

    assign prod  = $signed({1'b0, cnt_eff}) * mul_opnd;
    assign sum_s = $signed({{(PRW-TW){1'b0}}, sum_eff});

    // ------------------------------------------------------------------
    // Mode state machine next state
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] w_eff;
    logic                     over_temp;
    logic                     aux_hot;
    logic                     prot_recover;
    logic [TIME_W-1:0]        elapsed;
    logic                     cool_done;
    logic [MODE_W-1:0]        mode_next;
    logic                     pump_next;
    logic [DUTY_BITS-1:0]     blower_goal_next;
    logic                     deh_exit;
    logic [XW-1:0]            dry_x;
    logic [DUTY_BITS-1:0]     dry_goal;

    assign w_eff        = temp_ok_reg ? temp_reg : '0;
    assign over_temp    = temp_ok_reg && (w_eff > crit_reg);
    assign aux_hot      = temp_ok_reg && (w_eff > aux_level_reg);
    assign prot_recover = (mode_reg == ST_PROT) && (w_eff < aux_level_reg);
    assign elapsed      = now_reg - cool_start_reg;
    assign cool_done    = elapsed > TIME_W'(after_cool_reg);
    assign dry_x        = XW'(dry_reg);
    assign dry_goal     = (dry_x > XW'(DUTY_MAX)) ? DUTY_MAX : DUTY_BITS'(dry_x);

    always_comb
    begin
        mode_next = mode_reg;
        if (over_temp)
            mode_next = ST_PROT;
        else if (prot_recover)
            mode_next = ST_IDLE;

        if (mode_next != ST_PROT)
        begin
            case (mode_reg)
                ST_IDLE, ST_AFT:
                begin
                    if (lt_lo_reg)
                        mode_next = ST_HUM;
                    else if (gt_hi_reg)
                        mode_next = ST_DEH;
                    else if ((mode_reg == ST_AFT) && cool_done)
                        mode_next = ST_IDLE;
                end
                ST_HUM:
                begin
                    if (ge_t_reg)
                        mode_next = ST_IDLE;
                end
                ST_DEH:
                begin
                    if (le_t_reg)
                        mode_next = ST_AFT;
                end
                default: ;
            endcase
        end

        pump_next = (mode_next == ST_HUM) && temp_ok_reg && (w_eff >= warmup_reg);

        case (mode_next)
            ST_DEH:  blower_goal_next = DUTY_MAX;
            ST_AFT:  blower_goal_next = dry_goal;
            default: blower_goal_next = '0;
        endcase
    end

    assign deh_exit = (mode_reg == ST_DEH) && (mode_next != ST_DEH);

    // ------------------------------------------------------------------
    // Duty ramp
    // ------------------------------------------------------------------
    logic [RW-1:0]        step_x;
    logic [RW-1:0]        blower_sum;
    logic [RW-1:0]        case_sum;
    logic [RW-1:0]        case_gap;
    logic [DUTY_BITS-1:0] blower_next;
    logic [DUTY_BITS-1:0] case_next;

    assign step_x     = RW'(step_reg);
    assign blower_sum = {1'b0, blower_now_reg} + step_x;
    assign case_sum   = {1'b0, case_now_reg} + step_x;
    assign case_gap   = {1'b0, case_now_reg} - {1'b0, case_goal_reg};

    always_comb
    begin
        // blower: up by a step, or straight down to its goal
        if (blower_now_reg < blower_goal_reg)
            blower_next = (blower_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX
                                                          : blower_sum[DUTY_BITS-1:0];
        else if (blower_now_reg > blower_goal_reg)
            blower_next = blower_goal_reg;
        else
            blower_next = blower_now_reg;

        // case fan: steps both ways, stopping at its goal on the way down
        if (case_now_reg < case_goal_reg)
            case_next = (case_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX
                                                      : case_sum[DUTY_BITS-1:0];
        else if (case_now_reg > case_goal_reg)
            case_next = (case_gap > step_x) ? (case_now_reg - step_x[DUTY_BITS-1:0])
                                            : case_goal_reg;
        else
            case_next = case_now_reg;
    end

    // ------------------------------------------------------------------
    // Divider step
    // ------------------------------------------------------------------
    logic [CW:0]   rem_sh;
    logic          quo_bit;
    logic [CW:0]   rem_diff;
    logic [TW-1:0] div_next;

    assign rem_sh   = {rem_reg, div_reg[TW-1]};
    assign quo_bit  = rem_sh >= {1'b0, count};
    assign rem_diff = rem_sh - {1'b0, count};
    assign div_next = {div_reg[TW-2:0], quo_bit};

    // ------------------------------------------------------------------
    // Sample ring memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (seq_reg == SQ_RD)
            ring_rd_reg <= ring_mem[ptr_reg];
        if (seq_reg == SQ_PUSH)
            ring_mem[ptr_reg] <= hum_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer, controller state and report register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SQ_IDLE;
            mul_idx_reg     <= MUL_LO;
            div_cnt_reg     <= '0;
            mode_reg        <= ST_IDLE;
            cool_start_reg  <= '0;
            ptr_reg         <= '0;
            total_reg       <= '0;
            filled_reg      <= 1'b0;
            pump_reg        <= 1'b0;
            blower_goal_reg <= '0;
            blower_now_reg  <= '0;
            case_goal_reg   <= '0;
            case_now_reg    <= '0;
            avg_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // in SQ_DONE the report register is either reloaded or held
            if (report.ready && (seq_reg != SQ_DONE))
                out_valid_reg <= 1'b0;

            case (seq_reg)
                SQ_IDLE:
                begin
                    if (sample.valid)
                    begin
                        hum_reg     <= sample.humidity;
                        hum_ok_reg  <= sample.humidity_ok;
                        temp_reg    <= sample.water_temp;
                        temp_ok_reg <= sample.water_ok;
                        now_reg     <= sample.now_ms;
                        mul_idx_reg <= MUL_LO;
                        if (sample.mode == KIND_RAMP)
                            seq_reg <= SQ_RAMP;
                        else if (sample.humidity_ok)
                            seq_reg <= SQ_RD;
                        else
                            seq_reg <= SQ_MUL;
                    end
                end

                SQ_RAMP:
                begin
                    blower_now_reg <= blower_next;
                    case_now_reg   <= case_next;
                    seq_reg        <= SQ_DONE;
                end

                // oldest sample is read out this cycle
                SQ_RD:
                    seq_reg <= SQ_PUSH;

                SQ_PUSH:
                begin
                    total_reg <= total_reg - (filled_reg ? TW'(ring_rd_reg) : '0)
                                 + TW'(hum_reg);
                    if (ptr_reg == PW'(WINDOW - 1))
                    begin
                        ptr_reg    <= '0;
                        filled_reg <= 1'b1;
                    end
                    else
                        ptr_reg <= ptr_reg + PW'(1);
                    seq_reg <= SQ_MUL;
                end

                // three threshold products, one per cycle
                SQ_MUL:
                begin
                    case (mul_idx_reg)
                        MUL_LO: lt_lo_reg <= sum_s < prod;
                        MUL_HI: gt_hi_reg <= sum_s > prod;
                        default:
                        begin
                            ge_t_reg <= sum_s >= prod;
                            le_t_reg <= sum_s <= prod;
                        end
                    endcase
                    if (mul_idx_reg == MUL_TGT)
                        seq_reg <= SQ_FSM;
                    else
                        mul_idx_reg <= mul_idx_reg + 2'd1;
                end

                SQ_FSM:
                begin
                    mode_reg      <= mode_next;
                    pump_reg      <= pump_next;
                    case_goal_reg <= aux_hot ? DUTY_MAX : '0;
                    if (deh_exit)
                    begin
                        blower_now_reg  <= '0;
                        blower_goal_reg <= '0;
                    end
                    else
                        blower_goal_reg <= blower_goal_next;
                    if (deh_exit && (mode_next == ST_AFT))
                        cool_start_reg <= now_reg;
                    div_reg     <= total_reg;
                    rem_reg     <= '0;
                    div_cnt_reg <= DCW'(TW - 1);
                    seq_reg     <= hum_ok_reg ? SQ_DIV : SQ_DONE;
                end

                // restoring divide, one quotient bit per cycle
                SQ_DIV:
                begin
                    div_reg <= div_next;
                    rem_reg <= quo_bit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
                    if (div_cnt_reg == '0)
                    begin
                        avg_reg <= div_next[HUM_W-1:0];
                        seq_reg <= SQ_DONE;
                    end
                    else
                        div_cnt_reg <= div_cnt_reg - DCW'(1);
                end

                SQ_DONE:
                begin
                    if (!out_valid_reg || report.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_mode_reg   <= mode_reg;
                        out_heater_reg <= mode_reg inside {ST_HUM, ST_DEH};
                        out_pump_reg   <= pump_reg;
                        out_blower_reg <= blower_now_reg;
                        out_case_reg   <= case_now_reg;
                        out_avg_reg    <= avg_reg;
                        seq_reg        <= SQ_IDLE;
                    end
                end

                default:
                    seq_reg <= SQ_IDLE;
            endcase
        end
    end

    assign sample.ready        = (seq_reg == SQ_IDLE);
    assign report.valid        = out_valid_reg;
    assign report.mode_state   = out_mode_reg;
    assign report.heater_on    = out_heater_reg;
    assign report.pump_on      = out_pump_reg;
    assign report.blower_duty  = out_blower_reg;
    assign report.case_duty    = out_case_reg;
    assign report.humidity_avg = out_avg_reg;

`ifndef NO_ASSERTIONS
    // once the ring has wrapped it stays full
    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(filled_reg))
        else $error("ring fill flag dropped");

    // ring pointer stays inside the window
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PW'(WINDOW - 1))
        else $error("ring pointer out of range");

    // sequencer leaves idle only on an accepted beat
    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_IDLE) && !sample.valid |=> seq_reg == SQ_IDLE)
        else $error("sequencer started without a beat");

    // blower is never driven toward a duty while protecting
    a_prot_blower: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ST_PROT) |-> (blower_goal_reg == '0))
        else $error("blower goal set in protect mode");
`endif

endmodule

/* test/humidity_mode_controller_top_test.sv */
// ============================================================================
// humidity_mode_controller_top_test: self-checking bench for the controller
// Sends control samples and ramp ticks under several register settings and
// idle/stall profiles. A behavioral copy of the controller predicts every
// report, and each report beat is compared with the oldest prediction.
// ============================================================================
module humidity_mode_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hmc_pkg::*;

    localparam int DUTY_W        = DUTY_BITS_DEF;
    localparam int WIN           = WINDOW_DEF;
    localparam int DUTY_TOP      = (1 << DUTY_W) - 1;
    localparam int MAX_SHOWN     = 10;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_GAP       = 40;

    typedef struct {
        logic                     mode;
        logic [HUM_W-1:0]         humidity;
        logic                     humidity_ok;
        logic signed [TEMP_W-1:0] water_temp;
        logic                     water_ok;
        logic [TIME_W-1:0]        now_ms;
    } climate_beat_t;

    typedef struct {
        logic [MODE_W-1:0] mode_state;
        logic              heater_on;
        logic              pump_on;
        logic [DUTY_W-1:0] blower_duty;
        logic [DUTY_W-1:0] case_duty;
        logic [HUM_W-1:0]  humidity_avg;
    } climate_report_t;

    typedef struct {
        logic [HUM_W-1:0]         target;
        logic [BAND_W-1:0]        band;
        logic [COOL_W-1:0]        after_cool;
        logic signed [TEMP_W-1:0] warmup;
        logic signed [TEMP_W-1:0] fan_temp;
        logic signed [TEMP_W-1:0] critical;
        logic [DRY_W-1:0]         dry_duty;
        logic [STEP_W-1:0]        ramp_step;
    } climate_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    hmc_sample_if                              sample_ch ();
    hmc_report_if #(.DUTY_BITS(DUTY_BITS_DEF)) report_ch ();

    humidity_mode_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .report    (report_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller copy: registers, mode, filter and duty state
    climate_cfg_t      cfg = '{TARGET_RST, BAND_RST, AFTERCOOL_RST, WARMUP_RST,
                               AUXCOOL_RST, CRITICAL_RST, DRYDUTY_RST, RAMPSTEP_RST};
    logic [MODE_W-1:0] ctl_mode = ST_IDLE;
    logic [TIME_W-1:0] cool_start = '0;
    logic [HUM_W-1:0]  hum_ring [WIN];
    int unsigned       ring_slot = 0;
    int unsigned       ring_sum = 0;
    bit                ring_full = 1'b0;
    bit                pump_latched = 1'b0;
    int unsigned       blower_goal = 0;
    int unsigned       blower_now = 0;
    int unsigned       fan_goal = 0;
    int unsigned       fan_now = 0;

    climate_report_t   pending_reports [$];

    // Bench bookkeeping
    int          fail_count = 0;
    int          mismatch_count = 0;
    int          reports_checked = 0;
    int          beats_sent = 0;
    int          ticks_sent = 0;
    int          settings_applied = 0;
    int          mode_hits [ST_PROT+1];
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_id = 0;
    int          hold_seen = 0;
    int          hold_len = 0;
    int          hold_left = 0;
    int          hum_walk = 750;
    int          temp_walk = 600;
    logic [31:0] clock_ms = '0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Soft-start: move both duties toward their goals (blower drops straight down)
    function automatic void ramp_duties();
        int unsigned st;
        st = cfg.ramp_step;
        if (blower_now < blower_goal)
            blower_now += st;
        else if (blower_now > blower_goal)
            blower_now = blower_goal;
        if (fan_now < fan_goal)
            fan_now += st;
        else if (fan_now > fan_goal)
            fan_now = (fan_now - fan_goal > st) ? fan_now - st : fan_goal;
        if (blower_now > DUTY_TOP)
            blower_now = DUTY_TOP;
        if (fan_now > DUTY_TOP)
            fan_now = DUTY_TOP;
    endfunction

    // Filter update and mode machine for one control sample
    function automatic void run_control(input climate_beat_t s);
        int                w;
        longint            total;
        longint            cnt;
        longint            tgt;
        longint            hys;
        bit                hot;
        bit                warm_case;
        logic [MODE_W-1:0] cur;
        logic [MODE_W-1:0] nxt;
        logic [31:0]       elapsed;
        int unsigned       duty_b;

        w = s.water_ok ? int'($signed(s.water_temp)) : 0;
        if (s.humidity_ok)
        begin
            if (ring_full)
                ring_sum -= hum_ring[ring_slot];
            hum_ring[ring_slot] = s.humidity;
            ring_sum += s.humidity;
            ring_slot++;
            if (ring_slot >= WIN)
            begin
                ring_slot = 0;
                ring_full = 1'b1;
            end
        end
        cnt = ring_full ? WIN : ring_slot;
        total = ring_sum;
        if (cnt == 0)
        begin
            cnt = 1;
            total = 0;
        end
        tgt = longint'(cfg.target);
        hys = longint'(cfg.band);
        hot = s.water_ok && (w > int'(cfg.critical));
        warm_case = s.water_ok && (w > int'(cfg.fan_temp));

        cur = ctl_mode;
        nxt = ctl_mode;
        if (hot)
            nxt = ST_PROT;
        else if (cur == ST_PROT && w < int'(cfg.fan_temp))
            nxt = ST_IDLE;

        if (nxt != ST_PROT)
        begin
            if (cur == ST_IDLE || cur == ST_AFT)
            begin
                elapsed = s.now_ms - cool_start;
                if (total < cnt * (tgt - hys))
                    nxt = ST_HUM;
                else if (total > cnt * (tgt + hys))
                    nxt = ST_DEH;
                else if (cur == ST_AFT && elapsed > 32'(cfg.after_cool))
                    nxt = ST_IDLE;
            end
            else if (cur == ST_HUM)
            begin
                if (total >= cnt * tgt)
                    nxt = ST_IDLE;
            end
            else if (cur == ST_DEH)
            begin
                if (total <= cnt * tgt)
                begin
                    nxt = ST_AFT;
                    cool_start = s.now_ms;
                end
            end
        end

        pump_latched = 1'b0;
        duty_b = 0;
        if (nxt == ST_HUM)
            pump_latched = s.water_ok && (w >= int'(cfg.warmup));
        else if (nxt == ST_DEH)
            duty_b = DUTY_TOP;
        else if (nxt == ST_AFT)
            duty_b = cfg.dry_duty;

        // blower is cut at once when dehumidify ends
        if (cur == ST_DEH && nxt != ST_DEH)
        begin
            blower_now = 0;
            blower_goal = 0;
        end
        else
            blower_goal = duty_b;
        fan_goal = warm_case ? DUTY_TOP : 0;
        ctl_mode = nxt;
    endfunction

    // Advance the controller copy by one beat and return the report it gives
    function automatic climate_report_t advance_controller(input climate_beat_t s);
        climate_report_t r;
        int unsigned     cnt;
        if (s.mode == KIND_RAMP)
            ramp_duties();
        else
            run_control(s);
        cnt = ring_full ? WIN : ring_slot;
        r.mode_state   = ctl_mode;
        r.heater_on    = (ctl_mode == ST_HUM || ctl_mode == ST_DEH);
        r.pump_on      = pump_latched;
        r.blower_duty  = DUTY_W'(blower_now);
        r.case_duty    = DUTY_W'(fan_now);
        r.humidity_avg = (cnt != 0) ? HUM_W'(ring_sum / cnt) : '0;
        if (ctl_mode <= ST_PROT)
            mode_hits[ctl_mode]++;
        return r;
    endfunction

    // Report checker
    always @(posedge clk)
    begin : report_check
        climate_report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: report beat with none expected (mode %0d avg %0d)",
                             $time, report_ch.mode_state, report_ch.humidity_avg);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (want.mode_state !== report_ch.mode_state ||
                    want.heater_on !== report_ch.heater_on ||
                    want.pump_on !== report_ch.pump_on ||
                    want.blower_duty !== report_ch.blower_duty ||
                    want.case_duty !== report_ch.case_duty ||
                    want.humidity_avg !== report_ch.humidity_avg)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display({"%0t: report %0d mismatch: exp mode %0d heat %0d pump %0d ",
                                  "blower %0d fan %0d avg %0d / got mode %0d heat %0d ",
                                  "pump %0d blower %0d fan %0d avg %0d"},
                                 $time, reports_checked, want.mode_state, want.heater_on,
                                 want.pump_on, want.blower_duty, want.case_duty,
                                 want.humidity_avg, report_ch.mode_state,
                                 report_ch.heater_on, report_ch.pump_on,
                                 report_ch.blower_duty, report_ch.case_duty,
                                 report_ch.humidity_avg);
                end
            end
        end
    end

    // Report ready: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_id != hold_seen)
        begin
            hold_seen <= hold_id;
            hold_left <= hold_len;
            report_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            report_ch.ready <= 1'b0;
        end
        else
            report_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Send one sample beat, with a random gap before it
    task automatic send_beat(input climate_beat_t s);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.mode        <= s.mode;
        sample_ch.humidity    <= s.humidity;
        sample_ch.humidity_ok <= s.humidity_ok;
        sample_ch.water_temp  <= s.water_temp;
        sample_ch.water_ok    <= s.water_ok;
        sample_ch.now_ms      <= s.now_ms;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_reports.push_back(advance_controller(s));
        beats_sent++;
        if (s.mode == KIND_RAMP)
            ticks_sent++;
    endtask

    // Stop sending and wait until every predicted report has come back
    task automatic drain_reports();
        int waited;
        waited = 0;
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all registers; only called while the block is idle
    task automatic apply_settings(input climate_cfg_t c);
        write_reg(REG_TARGET, CFG_DAT_W'(c.target));
        write_reg(REG_BAND, CFG_DAT_W'(c.band));
        write_reg(REG_AFTERCOOL, CFG_DAT_W'(c.after_cool));
        write_reg(REG_WARMUP, CFG_DAT_W'(c.warmup));
        write_reg(REG_AUXCOOL, CFG_DAT_W'(c.fan_temp));
        write_reg(REG_CRITICAL, CFG_DAT_W'(c.critical));
        write_reg(REG_DRYDUTY, CFG_DAT_W'(c.dry_duty));
        write_reg(REG_RAMPSTEP, CFG_DAT_W'(c.ramp_step));
        cfg_we <= 1'b0;
        cfg = c;
        settings_applied++;
    endtask

    function automatic climate_beat_t control_beat(input logic [HUM_W-1:0] hum,
                                                   input logic hum_ok,
                                                   input logic signed [TEMP_W-1:0] wt,
                                                   input logic wt_ok,
                                                   input logic [TIME_W-1:0] now);
        climate_beat_t s;
        s.mode        = KIND_CONTROL;
        s.humidity    = hum;
        s.humidity_ok = hum_ok;
        s.water_temp  = wt;
        s.water_ok    = wt_ok;
        s.now_ms      = now;
        return s;
    endfunction

    // Ramp tick; the other fields carry noise the block must ignore
    function automatic climate_beat_t ramp_tick();
        climate_beat_t s;
        s.mode        = KIND_RAMP;
        s.humidity    = HUM_W'($urandom);
        s.humidity_ok = 1'($urandom_range(1));
        s.water_temp  = TEMP_W'($urandom);
        s.water_ok    = 1'($urandom_range(1));
        s.now_ms      = $urandom;
        return s;
    endfunction

    // Random beat: humidity and water temperature drift around the thresholds
    function automatic climate_beat_t next_random_beat();
        climate_beat_t s;
        int            pick;
        int            base;
        if ($urandom_range(99) < 35)
            return ramp_tick();

        pick = $urandom_range(99);
        if (pick < 3)
            hum_walk = $urandom_range(1023);
        else if (pick < 20)
            hum_walk = clamp_int(int'(cfg.target) + int'($urandom_range(4 * cfg.band + 120))
                                 - 2 * int'(cfg.band) - 60, 0, 1023);
        else
            hum_walk = clamp_int(hum_walk + int'($urandom_range(100)) - 50, 0, 1023);

        pick = $urandom_range(99);
        if (pick < 3)
            temp_walk = int'($urandom_range(4095)) - 2048;
        else if (pick < 18)
        begin
            case ($urandom_range(2))
                0: base = int'(cfg.warmup);
                1: base = int'(cfg.fan_temp);
                default: base = int'(cfg.critical);
            endcase
            temp_walk = clamp_int(base + int'($urandom_range(4)) - 2, -2048, 2047);
        end
        else
            temp_walk = clamp_int(temp_walk + int'($urandom_range(80)) - 40, -2048, 2047);

        // time mostly advances; now and then it jumps, sometimes just short of the wrap
        if ($urandom_range(99) < 2)
            clock_ms = $urandom_range(1) ? 32'($urandom)
                                         : 32'hFFFF_FFFF - $urandom_range(cfg.after_cool);
        else
            clock_ms += $urandom_range(cfg.after_cool / 6 + 50);

        s.mode        = KIND_CONTROL;
        s.humidity    = HUM_W'(hum_walk);
        s.humidity_ok = ($urandom_range(99) < 90);
        s.water_temp  = TEMP_W'(temp_walk);
        s.water_ok    = ($urandom_range(99) < 92);
        s.now_ms      = clock_ms;
        return s;
    endfunction

    function automatic climate_cfg_t random_settings();
        climate_cfg_t c;
        int           t0;
        int           t1;
        int           t2;
        int           sw;
        t0 = int'($urandom_range(2880)) - 880;
        t1 = int'($urandom_range(2880)) - 880;
        t2 = int'($urandom_range(2880)) - 880;
        // keep warmup <= fan level <= critical so every mode gets visited
        if (t0 > t1)
        begin
            sw = t0;
            t0 = t1;
            t1 = sw;
        end
        if (t1 > t2)
        begin
            sw = t1;
            t1 = t2;
            t2 = sw;
        end
        if (t0 > t1)
        begin
            sw = t0;
            t0 = t1;
            t1 = sw;
        end
        c.target     = HUM_W'($urandom_range(1000));
        c.band       = BAND_W'($urandom_range(200));
        c.after_cool = ($urandom_range(3) == 0) ? COOL_W'($urandom_range(600000))
                                                : COOL_W'($urandom_range(3000));
        c.warmup     = TEMP_W'(t0);
        c.fan_temp   = TEMP_W'(t1);
        c.critical   = TEMP_W'(t2);
        c.dry_duty   = DRY_W'($urandom_range(1023));
        c.ramp_step  = STEP_W'($urandom_range(255, 1));
        return c;
    endfunction

    // Random beats under each idle/stall profile in turn
    task automatic run_idle_profiles(input int beats_per_profile);
        int send_pcts [4] = '{0, 50, 0, 8};
        int stall_pcts [4] = '{0, 0, 50, 8};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = send_pcts[p];
            stall_pct = stall_pcts[p];
            repeat (beats_per_profile) send_beat(next_random_beat());
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // Hand-picked beats at reset settings: mode changes, time wrap, field extremes
    task automatic test_directed_cases();
        send_beat(ramp_tick());
        // first valid sample far above the band goes straight to dehumidify
        send_beat(control_beat(10'd1000, 1'b1, 12'sd700, 1'b1, 32'hFFFF_FFF0));
        send_beat(ramp_tick());
        send_beat(ramp_tick());
        // average falls to the set point: after-cool, blower cut, case fan on
        send_beat(control_beat(10'd500, 1'b1, 12'sd1000, 1'b1, 32'hFFFF_FFF0));
        send_beat(ramp_tick());
        // elapsed equal to the after-cool time across the time wrap: no timeout
        send_beat(control_beat(10'd750, 1'b1, 12'sd1000, 1'b1, 32'd44984));
        repeat (3) send_beat(ramp_tick());
        // one ms later it times out; a hot but invalid water reading is ignored
        send_beat(control_beat(10'd750, 1'b1, 12'sd2047, 1'b0, 32'd44985));
        // over-temperature, hold at the fan level, recover just below it
        send_beat(control_beat(10'd750, 1'b0, 12'sd2047, 1'b1, 32'd50000));
        send_beat(ramp_tick());
        send_beat(control_beat(10'd750, 1'b0, 12'sd960, 1'b1, 32'd50500));
        send_beat(control_beat(10'd750, 1'b0, 12'sd959, 1'b1, 32'd51000));
        send_beat(ramp_tick());
        // dry air: humidify, pump at and just below the warmup level
        send_beat(control_beat(10'd0, 1'b1, 12'sd640, 1'b1, 32'd51500));
        send_beat(control_beat(10'd0, 1'b1, 12'sd639, 1'b1, 32'd52000));
        send_beat(control_beat(10'd0, 1'b1, 12'h800, 1'b1, 32'd0));
        send_beat(control_beat(10'd1023, 1'b1, -12'sd1, 1'b0, 32'hFFFF_FFFF));
        send_beat(control_beat(10'd1023, 1'b1, 12'sd0, 1'b1, 32'h8000_0000));
        send_beat(ramp_tick());
    endtask

    // Register extremes: negative low threshold, top of range, full field widths
    task automatic test_register_extremes();
        climate_cfg_t low_cfg;
        climate_cfg_t high_cfg;
        climate_cfg_t wide_cfg;
        low_cfg  = '{10'd0, 8'd200, 20'd0, -12'sd880, -12'sd880, 12'sd2000,
                     10'd0, 8'd1};
        high_cfg = '{10'd1000, 8'd0, 20'd600000, 12'sd2000, 12'sd2000, 12'sd2000,
                     10'd1023, 8'd255};
        // 12'h800 is the most negative water temperature; ramp step of zero
        wide_cfg = '{10'd1023, 8'd255, 20'hFFFFF, 12'h800, 12'sd2047, 12'sd2047,
                     10'd1023, 8'd0};
        drain_reports();
        apply_settings(low_cfg);
        run_idle_profiles(40);
        drain_reports();
        apply_settings(high_cfg);
        run_idle_profiles(40);
        drain_reports();
        apply_settings(wide_cfg);
        run_idle_profiles(40);
    endtask

    // Random settings, one batch under each idle profile
    task automatic test_random_settings();
        drain_reports();
        apply_settings('{TARGET_RST, BAND_RST, AFTERCOOL_RST, WARMUP_RST, AUXCOOL_RST,
                         CRITICAL_RST, DRYDUTY_RST, RAMPSTEP_RST});
        run_idle_profiles(30);
        repeat (5)
        begin
            drain_reports();
            apply_settings(random_settings());
            run_idle_profiles(60);
        end
    endtask

    // Report side held off while beats keep coming; then a full pause
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (2)
        begin
            hold_len = 300;
            hold_id++;
            repeat (40) send_beat(next_random_beat());
            drain_reports();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.mode        = KIND_CONTROL;
        sample_ch.humidity    = '0;
        sample_ch.humidity_ok = 1'b0;
        sample_ch.water_temp  = '0;
        sample_ch.water_ok    = 1'b0;
        sample_ch.now_ms      = '0;
        report_ch.ready       = 1'b0;
        foreach (mode_hits[i])
            mode_hits[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        drain_reports();

        if (pending_reports.size() != 0)
        begin
            fail_count += pending_reports.size();
            $display("%0d expected reports never arrived", pending_reports.size());
        end
        $display("Covered %0d beats (%0d ramp ticks), %0d reports checked, %0d settings, %0d errors",
                 beats_sent, ticks_sent, reports_checked, settings_applied,
                 fail_count);
        $display({"Modes reached: idle %0d, humidify %0d, dehumidify %0d, ",
                  "after-cool %0d, protect %0d"},
                 mode_hits[ST_IDLE], mode_hits[ST_HUM], mode_hits[ST_DEH],
                 mode_hits[ST_AFT], mode_hits[ST_PROT]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hmc_pkg.sv
rtl/core/hmc_intf.sv
rtl/core/humidity_mode_controller_top.sv
test/humidity_mode_controller_top_test.sv
